// ----- design/lagb_pkg.sv -----
// ----------------------------------------------------------------------------
// lagb_pkg: shared types for the largest angular gap bisector
// Transfer payloads and the operation codes of the shared gap unit.
// ----------------------------------------------------------------------------
package lagb_pkg;

   localparam int ANGLE_W = 16;

   typedef struct packed {
      logic [ANGLE_W-1:0] edge_angle;
      logic               outgoing;
      logic               present;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] result_angle;
      logic               overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      UOP_NONE,
      UOP_CLR_MM,
      UOP_MINMAX,
      UOP_SEED,
      UOP_CLR_SUCC,
      UOP_SUCC,
      UOP_STEP,
      UOP_FINISH
   } uop_type;

endpackage

// ----- design/largest_angular_gap_bisector_core.sv -----
// ----------------------------------------------------------------------------
// largest_angular_gap_bisector_core: bisector of the largest angular gap
// Loads edge angles, then finds the widest circular gap by repeated scans.
// ----------------------------------------------------------------------------
// Edge items: one transfer per cycle while loading.
// Closing item: the result is registered after the scan passes, which are
//   skipped for an empty set; each scan pass reads the angle memory one entry
//   per cycle through one port.
// Input is stalled from the closing transfer until the result is registered.
// Reset clears edge count, overflow flag and handshake state; memory is not.
module largest_angular_gap_bisector_core #(
   parameter int MAX_EDGES  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lagb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lagb_pkg::rsp_type rsp_payload
);
   import lagb_pkg::*;

   localparam int AW = ANGLE_BITS;
   localparam int IW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam logic [AW-1:0] THREE_QTR = {2'b11, {(AW-2){1'b0}}};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MM,
      ST_SEED,
      ST_CHECK,
      ST_SUCC,
      ST_STEP,
      ST_FIN,
      ST_REPLY
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          empty_ff, empty_in;
   logic          issue_ff, issue_in;
   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic          dv_ff, dv_in;
   logic          dlast_ff, dlast_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_payload_ff, rsp_payload_in;

   uop_type       uop;
   logic          accept, room, wr_en;
   logic [AW-1:0] angle_raw, wr_data, rd_data, unit_res;
   logic [CW-1:0] count_after;
   logic [IW-1:0] last_idx;
   logic          cur_is_max;

   assign angle_raw   = AW'(req_payload.edge_angle);
   assign accept      = req_valid && (state_ff == ST_LOAD);
   assign room        = count_ff < CW'(MAX_EDGES);
   assign wr_en       = accept && req_payload.present && room;
   assign wr_data     = req_payload.outgoing ? angle_raw
                        : {~angle_raw[AW-1], angle_raw[AW-2:0]};
   assign count_after = count_ff + CW'(wr_en);
   assign last_idx    = IW'(count_ff - CW'(1));

   lagb_store #(
      .DEPTH (MAX_EDGES),
      .WIDTH (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   lagb_unit #(
      .ANGLE_BITS (AW)
   ) u_unit (
      .clock      (clock),
      .reset      (reset),
      .uop        (uop),
      .data       (rd_data),
      .cur_is_max (cur_is_max),
      .result     (unit_res)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      empty_in       = empty_ff;
      issue_in       = issue_ff;
      rd_addr_in     = rd_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      uop            = UOP_NONE;

      // memory read sequencing, one entry per cycle
      dv_in    = issue_ff;
      dlast_in = issue_ff && (rd_addr_ff == last_idx);
      if (issue_ff) begin
         if (rd_addr_ff == last_idx) begin
            issue_in = 1'b0;
         end else begin
            rd_addr_in = rd_addr_ff + 1'b1;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            uop = UOP_CLR_MM;
            if (accept) begin
               count_in = count_after;
               ovf_in   = ovf_ff | (req_payload.present && !room);
               if (req_payload.last_item) begin
                  if (count_after == '0) begin
                     empty_in = 1'b1;
                     state_in = ST_REPLY;
                  end else begin
                     empty_in   = 1'b0;
                     issue_in   = 1'b1;
                     rd_addr_in = '0;
                     state_in   = ST_MM;
                  end
               end
            end
         end
         ST_MM: begin
            uop = dv_ff ? UOP_MINMAX : UOP_NONE;
            if (dv_ff && dlast_ff) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            uop      = UOP_SEED;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            uop = UOP_CLR_SUCC;
            if (cur_is_max) begin
               state_in = ST_FIN;
            end else begin
               issue_in   = 1'b1;
               rd_addr_in = '0;
               state_in   = ST_SUCC;
            end
         end
         ST_SUCC: begin
            uop = dv_ff ? UOP_SUCC : UOP_NONE;
            if (dv_ff && dlast_ff) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            uop      = UOP_STEP;
            state_in = ST_CHECK;
         end
         ST_FIN: begin
            uop      = UOP_FINISH;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.result_angle =
                  empty_ff ? ANGLE_W'(THREE_QTR) : ANGLE_W'(unit_res);
               rsp_payload_in.overflowed = ovf_ff;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         issue_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         dlast_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         empty_ff     <= empty_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
         dlast_ff     <= dlast_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff     <= rd_addr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != ST_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES))
      else $error("edge count beyond capacity");

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result raised outside reply state");

   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      (dv_ff && dlast_ff) |=> !dv_ff)
      else $error("read data after last entry of pass");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MM || state_ff == ST_SUCC) |-> (count_ff != '0))
      else $error("scan of an empty set");

endmodule

// ----- design/lagb_store.sv -----
// ----------------------------------------------------------------------------
// lagb_store: angle memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lagb_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lagb_unit.sv -----
// ----------------------------------------------------------------------------
// lagb_unit: shared compare/subtract unit
// Tracks min/max, the next larger angle, the best gap and the bisector.
// ----------------------------------------------------------------------------
module lagb_unit #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lagb_pkg::uop_type     uop,
   input  logic [ANGLE_BITS-1:0] data,
   output logic                  cur_is_max,
   output logic [ANGLE_BITS-1:0] result
);
   import lagb_pkg::*;

   localparam int AW = ANGLE_BITS;
   localparam int GW = ANGLE_BITS + 1;
   localparam logic [GW-1:0] FULL_TURN = {1'b1, {AW{1'b0}}};

   logic [AW-1:0] min_ff, min_in, max_ff, max_in;
   logic [AW-1:0] cur_ff, cur_in, succ_ff, succ_in;
   logic [AW-1:0] start_ff, start_in, res_ff, res_in;
   logic [GW-1:0] best_ff, best_in;
   logic          found_ff, found_in;
   logic [GW-1:0] gap;
   logic [AW-1:0] mid;

   assign gap = {1'b0, succ_ff} - {1'b0, cur_ff};
   assign mid = start_ff + best_ff[AW:1];

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      cur_in   = cur_ff;
      succ_in  = succ_ff;
      start_in = start_ff;
      best_in  = best_ff;
      found_in = found_ff;
      res_in   = res_ff;
      case (uop)
         UOP_CLR_MM: begin
            min_in = '1;
            max_in = '0;
         end
         UOP_MINMAX: begin
            if (data < min_ff) begin
               min_in = data;
            end
            if (data > max_ff) begin
               max_in = data;
            end
         end
         UOP_SEED: begin
            // wrap gap is the first candidate
            best_in  = FULL_TURN - {1'b0, max_ff} + {1'b0, min_ff};
            start_in = max_ff;
            cur_in   = min_ff;
         end
         UOP_CLR_SUCC: begin
            found_in = 1'b0;
         end
         UOP_SUCC: begin
            if (data > cur_ff && (!found_ff || data < succ_ff)) begin
               succ_in  = data;
               found_in = 1'b1;
            end
         end
         UOP_STEP: begin
            if (gap > best_ff) begin
               best_in  = gap;
               start_in = cur_ff;
            end
            cur_in = succ_ff;
         end
         UOP_FINISH: begin
            res_in = '0 - mid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      min_ff   <= min_in;
      max_ff   <= max_in;
      cur_ff   <= cur_in;
      succ_ff  <= succ_in;
      start_ff <= start_in;
      best_ff  <= best_in;
      res_ff   <= res_in;
   end

   assign cur_is_max = (cur_ff == max_ff);
   assign result     = res_ff;

   a_step_found: assert property (@(posedge clock) disable iff (reset)
      (uop == UOP_STEP) |-> found_ff)
      else $error("step without a successor");

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      (uop == UOP_STEP) |-> (succ_ff > cur_ff))
      else $error("successor not above current angle");

   a_seed_span: assert property (@(posedge clock) disable iff (reset)
      (uop == UOP_SEED) |-> (min_ff <= max_ff))
      else $error("min above max at seed");

endmodule
